### design/pairwise_overlap_tally_macros.svh
// assertion macros for the pairwise overlap tally
// included by the top level, no other dependencies
`ifndef PAIRWISE_OVERLAP_TALLY_MACROS_SVH
`define PAIRWISE_OVERLAP_TALLY_MACROS_SVH
`ifndef NO_ASSERTIONS
`define POT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pot: same-cycle check failed");
`define POT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pot: next-cycle check failed");
`else
`define POT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define POT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/pot_pkg.sv
// shared constants, types and functions of the pairwise overlap tally
// no dependencies
package pot_pkg;

    localparam int NUM_SETS      = 8;
    localparam int COUNTER_WIDTH = 32;

    localparam int GROUP_FIELDS = 5;
    localparam int ATTR_NUM     = 4;
    localparam int ATTR_W       = 8;
    localparam int MASK_W       = 8;
    localparam int IDX_W        = 3;
    localparam int SEL_W        = 5;
    localparam int READ_W       = 32;
    localparam int FLD_W        = 3;
    localparam int GRP_W        = 2;
    localparam int SEL_LIMIT    = 20;

    localparam int SET_W      = $clog2(NUM_SETS);
    localparam int ADDR_W     = 2 * SET_W + GRP_W;
    localparam int MEM_DEPTH  = 1 << ADDR_W;
    localparam int WIDE_W     = (COUNTER_WIDTH > READ_W) ? COUNTER_WIDTH : READ_W;
    localparam int MASKX_W    = (NUM_SETS > MASK_W) ? NUM_SETS : MASK_W;

    localparam logic [GRP_W-1:0] GRP_A  = 2'd0;
    localparam logic [GRP_W-1:0] GRP_AB = 2'd1;
    localparam logic [GRP_W-1:0] GRP_B  = 2'd2;
    localparam logic [GRP_W-1:0] GRP_E  = 2'd3;

    localparam logic OP_ACC  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef logic [COUNTER_WIDTH-1:0]           t_counter;
    typedef t_counter [GROUP_FIELDS-1:0]        t_group;
    typedef logic [ATTR_NUM-1:0][ATTR_W-1:0]    t_attr;
    typedef logic [ADDR_W-1:0]                  t_addr;

    typedef struct packed {
        logic              opcode;
        logic [MASK_W-1:0] presence_mask;
        logic [ATTR_W-1:0] transition_count;
        logic [ATTR_W-1:0] transversion_count;
        logic [ATTR_W-1:0] insertion_count;
        logic [ATTR_W-1:0] deletion_count;
        logic [IDX_W-1:0]  row_set;
        logic [IDX_W-1:0]  column_set;
        logic [SEL_W-1:0]  counter_select;
    } t_in_item;

    typedef struct packed {
        logic [READ_W-1:0] read_value;
        logic              is_read_result;
    } t_out_item;

    typedef struct packed {
        logic  rd_en;
        logic  rmw;
        logic  clr;
        t_addr addr;
    } t_bank_req;

    function automatic t_counter sat_add(input t_counter v, input t_counter x);
        logic [COUNTER_WIDTH:0] s;
        s = {1'b0, v} + {1'b0, x};
        return s[COUNTER_WIDTH] ? '1 : s[COUNTER_WIDTH-1:0];
    endfunction

    function automatic t_addr make_addr(input logic [SET_W-1:0] i,
                                        input logic [SET_W-1:0] j,
                                        input logic [GRP_W-1:0] g);
        return {i, j, g};
    endfunction

endpackage

### design/pot_channels.sv
// valid/ready channel interfaces for input and result transactions
// depends on pot_pkg
interface pot_in_if;
    import pot_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface pot_out_if;
    import pot_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### design/pot_bank.sv
// counter memory: one row of five saturating counters per pair and group,
// with a read port and a read-modify-write update stage; depends on pot_pkg
module pot_bank (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pot_pkg::t_bank_req i_req,
    input  pot_pkg::t_attr     i_attr,
    output pot_pkg::t_group    o_rdata
);
    import pot_pkg::*;

    t_group r_mem [MEM_DEPTH];
    t_group r_rdata;
    logic   r_upd;
    t_addr  r_upd_addr;
    t_group n_group;

    always_comb begin
        n_group[0] = sat_add(r_rdata[0], COUNTER_WIDTH'(1));
        for (int k = 1; k < GROUP_FIELDS; k++) begin
            n_group[k] = sat_add(r_rdata[k], COUNTER_WIDTH'(i_attr[k-1]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upd <= 1'b0;
        end else begin
            r_upd <= i_req.rd_en && i_req.rmw;
        end
        r_upd_addr <= i_req.addr;
    end

    always_ff @(posedge i_clk) begin
        if (i_req.clr) begin
            r_mem[i_req.addr] <= '0;
        end else if (r_upd) begin
            r_mem[r_upd_addr] <= n_group;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/pairwise_overlap_tally.sv
// pairwise overlap tally, top level: sequencer over the counter memory
// accumulate: NUM_SETS*NUM_SETS+1 memory steps (one pair per cycle plus the
// exclusive row); read: one memory read through states RD1 and RD2, then DONE
// one transaction at a time, set by the single read-modify-write port of pot_bank
// reset: synchronous, active low; a clearing pass over all 256 addresses zeroes the memory
// before the first transaction is accepted
`include "pairwise_overlap_tally_macros.svh"
module pairwise_overlap_tally (
    input  logic i_clk,
    input  logic i_rst_n,
    pot_in_if.sink    i_item,
    pot_out_if.source o_result
);
    import pot_pkg::*;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_ACC   = 6'b000100,
        ST_RD1   = 6'b001000,
        ST_RD2   = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    t_addr             r_clr_addr, n_clr_addr;
    logic [SET_W-1:0]  r_i, n_i, r_j, n_j;
    logic              r_excl, n_excl;
    logic              r_out_valid, n_out_valid;
    logic [NUM_SETS-1:0] r_pres;
    t_attr             r_attr;
    logic [IDX_W-1:0]  r_row, r_col;
    logic [SEL_W-1:0]  r_sel;
    logic              r_opcode;
    logic [READ_W-1:0] r_res;
    logic [READ_W-1:0] r_out_value;
    logic              r_out_is_read;

    t_bank_req         bank_req;
    t_group            bank_rdata;
    logic              accept;
    logic [MASKX_W-1:0] maskx;
    logic              excl_found, excl_multi;
    logic [SET_W-1:0]  excl_idx;
    logic              pres_i, pres_j;
    logic [GRP_W-1:0]  pair_grp, rd_grp;
    logic [FLD_W-1:0]  rd_fld, rd_fld_idx;
    logic [SEL_W-1:0]  rd_base;
    logic              rd_ok;
    logic [WIDE_W-1:0] rd_wide;

    assign accept = i_item.valid && i_item.ready;
    assign maskx  = MASKX_W'(i_item.payload.presence_mask);

    always_comb begin
        excl_found = 1'b0;
        excl_multi = 1'b0;
        excl_idx   = '0;
        for (int k = 0; k < NUM_SETS; k++) begin
            if (r_pres[k]) begin
                if (excl_found) begin
                    excl_multi = 1'b1;
                end
                excl_found = 1'b1;
                excl_idx   = SET_W'(k);
            end
        end
    end

    assign pres_i = r_pres[r_i];
    assign pres_j = r_pres[r_j];

    always_comb begin
        if (pres_i && !pres_j) begin
            pair_grp = GRP_A;
        end else if (pres_i && pres_j) begin
            pair_grp = GRP_AB;
        end else begin
            pair_grp = GRP_B;
        end
    end

    // counter select split into group and field
    always_comb begin
        if (r_sel < SEL_W'(5)) begin
            rd_grp  = GRP_A;
            rd_base = SEL_W'(0);
        end else if (r_sel < SEL_W'(10)) begin
            rd_grp  = GRP_AB;
            rd_base = SEL_W'(5);
        end else if (r_sel < SEL_W'(15)) begin
            rd_grp  = GRP_B;
            rd_base = SEL_W'(10);
        end else begin
            rd_grp  = GRP_E;
            rd_base = SEL_W'(15);
        end
        rd_fld = FLD_W'(r_sel - rd_base);
        rd_ok  = (32'(r_row) < NUM_SETS) && (32'(r_col) < NUM_SETS)
              && (32'(r_sel) < SEL_LIMIT) && ((rd_grp != GRP_E) || (r_row == r_col));
        rd_fld_idx = rd_ok ? rd_fld : '0;
        rd_wide    = WIDE_W'(bank_rdata[rd_fld_idx]);
    end

    always_comb begin
        bank_req = '0;
        unique case (r_state)
            ST_CLEAR: begin
                bank_req.clr  = 1'b1;
                bank_req.addr = r_clr_addr;
            end
            ST_ACC: begin
                bank_req.rmw = 1'b1;
                if (r_excl) begin
                    bank_req.rd_en = excl_found && !excl_multi;
                    bank_req.addr  = make_addr(excl_idx, excl_idx, GRP_E);
                end else begin
                    bank_req.rd_en = pres_i || pres_j;
                    bank_req.addr  = make_addr(r_i, r_j, pair_grp);
                end
            end
            ST_RD1: begin
                bank_req.rd_en = 1'b1;
                bank_req.addr  = make_addr(SET_W'(r_row), SET_W'(r_col), rd_grp);
            end
            ST_IDLE, ST_RD2, ST_DONE: begin
                bank_req = '0;
            end
            default: begin
                bank_req = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_i         = r_i;
        n_j         = r_j;
        n_excl      = r_excl;
        n_out_valid = r_out_valid;
        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_excl  = 1'b0;
                    n_state = (i_item.payload.opcode == OP_ACC) ? ST_ACC : ST_RD1;
                end
            end
            ST_ACC: begin
                if (r_excl) begin
                    n_state = ST_DONE;
                end else if (r_j == SET_W'(NUM_SETS - 1)) begin
                    n_j = '0;
                    if (r_i == SET_W'(NUM_SETS - 1)) begin
                        n_excl = 1'b1;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            ST_RD1: begin
                n_state = ST_RD2;
            end
            ST_RD2: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_excl      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_i         <= n_i;
            r_j         <= n_j;
            r_excl      <= n_excl;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_opcode <= i_item.payload.opcode;
            r_pres   <= maskx[NUM_SETS-1:0];
            r_attr   <= {i_item.payload.deletion_count, i_item.payload.insertion_count,
                         i_item.payload.transversion_count,
                         i_item.payload.transition_count};
            r_row    <= i_item.payload.row_set;
            r_col    <= i_item.payload.column_set;
            r_sel    <= i_item.payload.counter_select;
            r_res    <= '0;
        end else if (r_state == ST_RD2) begin
            r_res <= rd_ok ? rd_wide[READ_W-1:0] : '0;
        end
        if (r_state == ST_DONE && (!r_out_valid || o_result.ready)) begin
            r_out_value   <= r_res;
            r_out_is_read <= (r_opcode == OP_READ);
        end
    end

    pot_bank u_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (bank_req),
        .i_attr  (r_attr),
        .o_rdata (bank_rdata)
    );

    assign i_item.ready                    = (r_state == ST_IDLE);
    assign o_result.valid                  = r_out_valid;
    assign o_result.payload.read_value     = r_out_value;
    assign o_result.payload.is_read_result = r_out_is_read;

    `POT_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, accept, r_state != ST_IDLE)
    `POT_ASSERT_IMP(a_acc_result_zero, i_clk, i_rst_n, o_result.valid && !o_result.payload.is_read_result, o_result.payload.read_value == '0)
    `POT_ASSERT_NEXT(a_done_holds, i_clk, i_rst_n, r_state == ST_DONE && r_out_valid && !o_result.ready, r_state == ST_DONE)

endmodule

### sim/pairwise_overlap_tally_tb.sv
// testbench for the pairwise overlap tally: directed and random accumulate and read
// transactions, a scoreboard class that mirrors the saturating counter matrix
// depends on pot_pkg, pot_channels.sv and the pairwise_overlap_tally rtl
package pot_tb_pkg;
    import pot_pkg::*;

    class overlap_tally_model;
        t_counter    pair_totals [NUM_SETS][NUM_SETS][3][GROUP_FIELDS];
        t_counter    excl_totals [NUM_SETS][GROUP_FIELDS];
        t_out_item   pending [$];
        int unsigned failures;

        function new();
            foreach (pair_totals[i, j, g, f]) pair_totals[i][j][g][f] = '0;
            foreach (excl_totals[i, f]) excl_totals[i][f] = '0;
            failures = 0;
        endfunction

        function t_counter clamp_add(t_counter v, t_counter x);
            logic [COUNTER_WIDTH:0] s;
            s = {1'b0, v} + {1'b0, x};
            return s[COUNTER_WIDTH] ? {COUNTER_WIDTH{1'b1}} : s[COUNTER_WIDTH-1:0];
        endfunction

        function void note_item(t_in_item it);
            t_out_item   exp;
            t_counter    add_by [GROUP_FIELDS];
            logic        present [NUM_SETS];
            int          n_present;
            int          grp;
            int          fld;
            t_counter    val;
            n_present = 0;
            if (it.opcode == OP_ACC) begin
                add_by[0] = t_counter'(1);
                add_by[1] = t_counter'(it.transition_count);
                add_by[2] = t_counter'(it.transversion_count);
                add_by[3] = t_counter'(it.insertion_count);
                add_by[4] = t_counter'(it.deletion_count);
                for (int k = 0; k < NUM_SETS; k++) begin
                    present[k] = (k < MASK_W) ? it.presence_mask[k] : 1'b0;
                    if (present[k]) n_present++;
                end
                for (int i = 0; i < NUM_SETS; i++) begin
                    for (int j = 0; j < NUM_SETS; j++) begin
                        if (present[i] && !present[j]) grp = GRP_A;
                        else if (present[i] && present[j]) grp = GRP_AB;
                        else if (present[j]) grp = GRP_B;
                        else continue;
                        for (int f = 0; f < GROUP_FIELDS; f++)
                            pair_totals[i][j][grp][f] =
                                clamp_add(pair_totals[i][j][grp][f], add_by[f]);
                    end
                    if (present[i] && n_present == 1) begin
                        for (int f = 0; f < GROUP_FIELDS; f++)
                            excl_totals[i][f] = clamp_add(excl_totals[i][f], add_by[f]);
                    end
                end
                exp.read_value     = '0;
                exp.is_read_result = 1'b0;
            end else begin
                val = '0;
                if (it.row_set < NUM_SETS && it.column_set < NUM_SETS
                        && it.counter_select < SEL_LIMIT) begin
                    grp = it.counter_select / GROUP_FIELDS;
                    fld = it.counter_select % GROUP_FIELDS;
                    if (grp != GRP_E)
                        val = pair_totals[it.row_set][it.column_set][grp][fld];
                    else if (it.row_set == it.column_set)
                        val = excl_totals[it.row_set][fld];
                end
                exp.read_value     = val[READ_W-1:0];
                exp.is_read_result = 1'b1;
            end
            pending.insert(pending.size(), exp);
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp;
            if (pending.size() == 0) begin
                $error("result with nothing pending: read_value %0h is_read_result %0b",
                       got.read_value, got.is_read_result);
                failures++;
                return;
            end
            exp = pending.pop_front();
            if (got.read_value !== exp.read_value) begin
                $error("read_value: expected %0h, got %0h", exp.read_value, got.read_value);
                failures++;
            end
            if (got.is_read_result !== exp.is_read_result) begin
                $error("is_read_result: expected %0b, got %0b",
                       exp.is_read_result, got.is_read_result);
                failures++;
            end
        endfunction
    endclass
endpackage

module pairwise_overlap_tally_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pot_pkg::*;
    import pot_tb_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 244;
    localparam int SETTLE_CYCLES = 80;
    localparam int IN_W = $bits(t_in_item);

    logic i_clk;
    logic i_rst_n;
    int   src_idle_pct;
    int   sink_idle_pct;
    int unsigned cycle_count;

    overlap_tally_model tally = new();

    pot_in_if  item_ch ();
    pot_out_if result_ch ();

    pairwise_overlap_tally u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result before input: a result never answers the transaction accepted at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (result_ch.valid && result_ch.ready) tally.check_result(result_ch.payload);
            if (item_ch.valid && item_ch.ready) tally.note_item(item_ch.payload);
        end
    end

    always @(negedge i_clk) begin
        result_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    function automatic t_in_item site(logic [MASK_W-1:0] mask, logic [ATTR_W-1:0] ts,
                                      logic [ATTR_W-1:0] tv, logic [ATTR_W-1:0] ins,
                                      logic [ATTR_W-1:0] del);
        t_in_item it;
        it.opcode             = OP_ACC;
        it.presence_mask      = mask;
        it.transition_count   = ts;
        it.transversion_count = tv;
        it.insertion_count    = ins;
        it.deletion_count     = del;
        it.row_set            = IDX_W'($urandom);
        it.column_set         = IDX_W'($urandom);
        it.counter_select     = SEL_W'($urandom);
        return it;
    endfunction

    function automatic t_in_item lookup(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                        logic [SEL_W-1:0] sel);
        t_in_item it;
        it                = IN_W'({$urandom, $urandom});
        it.opcode         = OP_READ;
        it.row_set        = row;
        it.column_set     = col;
        it.counter_select = sel;
        return it;
    endfunction

    task automatic push_item(t_in_item it);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            item_ch.valid   <= 1'b0;
            item_ch.payload <= IN_W'({$urandom, $urandom});
            @(negedge i_clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.payload <= it;
        do @(posedge i_clk); while (!item_ch.ready);
    endtask

    task automatic hold_until_settled();
        @(negedge i_clk);
        item_ch.valid <= 1'b0;
        while (tally.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(int src_pct, int sink_pct);
        logic [MASK_W-1:0] mask;
        logic [IDX_W-1:0]  row;
        logic [SEL_W-1:0]  sel;
        int                pick;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 50) begin
                pick = $urandom_range(0, 99);
                if (pick < 30) mask = MASK_W'(1 << $urandom_range(0, MASK_W - 1));
                else if (pick < 40) mask = '0;
                else if (pick < 50) mask = '1;
                else mask = MASK_W'($urandom);
                push_item(site(mask, ATTR_W'($urandom), ATTR_W'($urandom),
                               ATTR_W'($urandom), ATTR_W'($urandom)));
            end else begin
                row = IDX_W'($urandom);
                sel = ($urandom_range(0, 99) < 80) ? SEL_W'($urandom_range(0, SEL_LIMIT - 1))
                                                   : SEL_W'($urandom);
                if (sel >= GRP_E * GROUP_FIELDS && sel < SEL_LIMIT
                        && $urandom_range(0, 99) < 70)
                    push_item(lookup(row, row, sel));
                else
                    push_item(lookup(row, IDX_W'($urandom), sel));
            end
        end
        hold_until_settled();
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        item_ch.valid   <= 1'b0;
        item_ch.payload <= '0;
        src_idle_pct     = 0;
        sink_idle_pct    = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty memory, empty mask, exclusive sites, full mask, extremes
        src_idle_pct  = 8;
        sink_idle_pct = 30;
        push_item(lookup(0, 0, 0));
        push_item(site('0, '1, '1, '1, '1));
        push_item(site(8'h01, '1, '1, '1, '1));
        push_item(site(8'h80, '0, '0, '0, '0));
        push_item(site('1, '1, '1, '1, '1));
        push_item(site(8'h5a, 8'd1, 8'd2, 8'd3, 8'd4));
        for (int s = 0; s < SEL_LIMIT; s += 3)
            push_item(lookup(0, (s >= GRP_E * GROUP_FIELDS) ? IDX_W'(0) : IDX_W'(7),
                             SEL_W'(s)));
        push_item(lookup(7, 7, SEL_W'(SEL_LIMIT - 1)));
        push_item(lookup(0, 7, SEL_W'(GRP_E * GROUP_FIELDS)));
        push_item(lookup(7, 7, SEL_W'(SEL_LIMIT)));
        push_item(lookup(7, 0, '1));
        hold_until_settled();

        run_phase(8, 88);
        run_phase(88, 8);
        run_phase(0, 0);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tally.failures == 0 && tally.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
